### src/tpc_pkg.sv
package tpc_pkg;

  // Field and datapath widths.
  localparam int IntervalW = 32;
  localparam int ClockW    = 8;
  localparam int TickW     = IntervalW + ClockW;   // interval_us * clock_mhz
  localparam int TickShift = 16;
  localparam int PscW      = TickW - TickShift;    // full prescaler before truncation
  localparam int DivW      = PscW + 1;             // prescaler + 1 can reach 2**PscW
  localparam int QuotW     = TickShift;            // the quotient always fits 16 bits
  localparam int FieldW    = 16;

  // The divider resolves this many quotient bits per pipeline stage.
  localparam int StepsPerStage = 2;
  localparam int DivStages     = QuotW / StepsPerStage;

  localparam logic [ClockW-1:0]    ClockMhzReset    = 8'd72;
  localparam logic [IntervalW-1:0] MaxIntervalReset = 32'd59652323;
  localparam logic [FieldW-1:0]    FieldMax         = 16'hFFFF;

  typedef enum logic {
    REG_CLOCK_MHZ    = 1'b0,
    REG_MAX_INTERVAL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ClockW-1:0]    clock_mhz;
    logic [IntervalW-1:0] max_interval_us;
  } cfg_t;

  typedef struct packed {
    logic [TickW-1:0] ticks;
    logic             over_limit;
  } mul_t;

  typedef struct packed {
    logic [DivW-1:0]  divisor;
    logic [PscW-1:0]  rem;
    logic [QuotW-1:0] low_bits;
    logic [QuotW-1:0] quot;
    logic [PscW-1:0]  psc;
    logic             over_limit;
  } div_t;

  // Sets up the long division of the tick count by prescaler + 1. The upper
  // tick bits equal the prescaler, which is already below the divisor, so
  // they form the starting remainder and only the low bits remain to shift in.
  function automatic div_t div_init(input mul_t m);
    div_t d;
    d.psc        = m.ticks[TickW-1:TickShift];
    d.rem        = m.ticks[TickW-1:TickShift];
    d.divisor    = {1'b0, m.ticks[TickW-1:TickShift]} + DivW'(1);
    d.low_bits   = m.ticks[TickShift-1:0];
    d.quot       = '0;
    d.over_limit = m.over_limit;
    return d;
  endfunction

endpackage

### src/timer_prescaler_period_calc.sv
// Channel   Handshake                     Payload
// input     in_valid_i / in_ready_o       interval_us_i
// output    out_valid_o / out_ready_i     prescaler_o, reload_period_o, over_limit_o
// config    cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// One beat enters per clock unless a stall holds the pipeline. A result passes through
// ten registers, the first loaded at the edge that accepts its input beat: one multiplier
// stage, eight divider stages of two quotient bits each, and the output register. The
// sixteen dependent subtract steps of the divider set that depth.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Every stage holds its beat while the next one is full, so a stall fills bubbles
// first and loses or repeats nothing. Configuration writes are taken every cycle.
module timer_prescaler_period_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       interval_us_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       prescaler_o,
  output logic [15:0]       reload_period_o,
  output logic              over_limit_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  tpc_pkg::cfg_reg_e cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import tpc_pkg::*;

  cfg_t cfg;

  // The register file never pushes back.
  assign cfg_ready_o = 1'b1;

  tpc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage one forms the tick count and checks the interval against the limit.
  logic mul_valid;
  mul_t mul_data;

  logic [DivStages:0] div_valid;
  logic [DivStages:0] div_ready;
  div_t               div_data [DivStages+1];

  tpc_mul_stage u_mul_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .interval_us_i (interval_us_i),
    .valid_o       (mul_valid),
    .ready_i       (div_ready[0]),
    .data_o        (mul_data)
  );

  // The divisor is prescaler + 1. With a zero prescaler it is one and the
  // quotient is the tick count itself, so no special path is needed. The
  // quotient never exceeds sixteen bits, which makes the saturation of the
  // period unreachable apart from the over-limit case.
  assign div_valid[0] = mul_valid;
  assign div_data[0]  = div_init(mul_data);

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    tpc_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  // Output register: decrements a nonzero period, truncates the prescaler,
  // and forces both fields to all ones for an over-limit interval.
  logic              out_valid_q;
  logic [FieldW-1:0] prescaler_q;
  logic [FieldW-1:0] prescaler_d;
  logic [FieldW-1:0] period_q;
  logic [FieldW-1:0] period_d;
  logic              over_q;
  div_t              fin;

  assign fin               = div_data[DivStages];
  assign div_ready[DivStages] = !out_valid_q || out_ready_i;

  always_comb begin
    if (fin.over_limit) begin
      prescaler_d = FieldMax;
      period_d    = FieldMax;
    end else begin
      prescaler_d = fin.psc[FieldW-1:0];
      period_d    = (fin.quot == '0) ? '0 : FieldW'(fin.quot - QuotW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready[DivStages]) begin
      out_valid_q <= div_valid[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid[DivStages] && div_ready[DivStages]) begin
      prescaler_q <= prescaler_d;
      period_q    <= period_d;
      over_q      <= fin.over_limit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prescaler_o     = prescaler_q;
  assign reload_period_o = period_q;
  assign over_limit_o    = over_q;

endmodule

### src/tpc_cfg_regs.sv
module tpc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  tpc_pkg::cfg_reg_e cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output tpc_pkg::cfg_t     cfg_o
);
  import tpc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_mhz       <= ClockMhzReset;
      cfg_q.max_interval_us <= MaxIntervalReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLOCK_MHZ:    cfg_q.clock_mhz       <= cfg_data_i[ClockW-1:0];
        REG_MAX_INTERVAL: cfg_q.max_interval_us <= cfg_data_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/tpc_mul_stage.sv
module tpc_mul_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpc_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [31:0]   interval_us_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tpc_pkg::mul_t data_o
);
  import tpc_pkg::*;

  logic valid_q;
  mul_t data_q;
  mul_t data_d;

  always_comb begin
    data_d.ticks      = TickW'(interval_us_i) * TickW'(cfg_i.clock_mhz);
    data_d.over_limit = interval_us_i > cfg_i.max_interval_us;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### src/tpc_div_stage.sv
module tpc_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tpc_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tpc_pkg::div_t data_o
);
  import tpc_pkg::*;

  logic            valid_q;
  div_t            data_q;
  div_t            data_d;
  logic [DivW-1:0] trial;

  // Restoring division: each step brings down one dividend bit and
  // subtracts the divisor when the partial remainder reaches it.
  always_comb begin
    data_d = data_i;
    trial  = '0;
    for (int s = 0; s < StepsPerStage; s++) begin
      trial           = {data_d.rem, data_d.low_bits[QuotW-1]};
      data_d.low_bits = {data_d.low_bits[QuotW-2:0], 1'b0};
      if (trial >= data_d.divisor) begin
        data_d.rem  = PscW'(trial - data_d.divisor);
        data_d.quot = {data_d.quot[QuotW-2:0], 1'b1};
      end else begin
        data_d.rem  = trial[PscW-1:0];
        data_d.quot = {data_d.quot[QuotW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
